FILE: hw/rtl/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

    // field widths and fixed-point format
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DW         = DATA_WIDTH;
    localparam int PW         = 2 * DW;     // full product width
    localparam int SW         = PW + 2;     // signed sum of two products
    localparam int NW         = PW + 1;     // magnitude of such a sum
    localparam int NCELLS     = DW;         // one quotient bit / root bit per cell

    // operation codes
    typedef logic [2:0] op_t;
    localparam op_t OP_ADD = 3'd0;
    localparam op_t OP_SUB = 3'd1;
    localparam op_t OP_MUL = 3'd2;
    localparam op_t OP_DIV = 3'd3;
    localparam op_t OP_NEG = 3'd4;
    localparam op_t OP_MAG = 3'd5;

    // status codes
    typedef logic [1:0] st_t;
    localparam st_t ST_OK  = 2'd0;
    localparam st_t ST_SAT = 2'd1;
    localparam st_t ST_DZ  = 2'd2;

    // which result is finished after the cell chain
    typedef enum logic [1:0] {
        LATE_NONE,
        LATE_DIV,
        LATE_MAG
    } late_t;

    // saturated part
    typedef struct packed {
        logic          sat;
        logic [DW-1:0] val;
    } nar_t;

    // word handed from cell to cell
    typedef struct packed {
        late_t         late;
        logic [DW-1:0] pre_re;
        logic [DW-1:0] pre_im;
        st_t           pre_st;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [PW-1:0] den;
        logic [PW-1:0] drem_re;
        logic [PW-1:0] drem_im;
        logic [DW-1:0] dsh_re;
        logic [DW-1:0] dsh_im;
        logic [DW-1:0] q_re;
        logic [DW-1:0] q_im;
        logic [DW+3:0] srem;
        logic [DW-1:0] root;
        logic [PW-1:0] vsh;
    } lane_t;

    // clamp a sign and magnitude to the signed output range
    function automatic nar_t sat_val(input logic neg, input logic [NW-1:0] m);
        nar_t          r;
        logic [NW-1:0] lim_p;
        logic [NW-1:0] lim_n;
        lim_p = NW'({(DW-1){1'b1}});
        lim_n = lim_p + 1'b1;
        r.sat = 1'b0;
        if (!neg && (m > lim_p)) begin
            r.sat = 1'b1;
            r.val = {1'b0, {(DW-1){1'b1}}};
        end else if (neg && (m > lim_n)) begin
            r.sat = 1'b1;
            r.val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r.val = neg ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
        end
        return r;
    endfunction

    // absolute value of a wide signed sum
    function automatic logic [NW-1:0] mag_of(input logic signed [SW-1:0] s);
        logic [SW-1:0] a;
        a = s[SW-1] ? (~s + 1'b1) : s;
        return a[NW-1:0];
    endfunction

endpackage

FILE: hw/rtl/cau_req_if.sv
`timescale 1ns / 1ps

interface cau_req_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  req_type;
    logic signed [cau_pkg::DW-1:0] a_re;
    logic signed [cau_pkg::DW-1:0] a_im;
    logic signed [cau_pkg::DW-1:0] b_re;
    logic signed [cau_pkg::DW-1:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: hw/rtl/cau_res_if.sv
`timescale 1ns / 1ps

interface cau_res_if;
    logic                        valid;
    logic                        ready;
    logic signed [cau_pkg::DW-1:0] res_re;
    logic signed [cau_pkg::DW-1:0] res_im;
    logic [1:0]                  status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

FILE: hw/rtl/cau_front.sv
`timescale 1ns / 1ps

module cau_front (
    input  logic           clk,
    input  logic           rst_n,
    cau_req_if.sink        req,
    output logic           dn_valid,
    input  logic           dn_ready,
    output cau_pkg::lane_t dn_lane
);
    import cau_pkg::*;

    typedef struct packed {
        op_t                  op;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] d_r;
        logic signed [PW-1:0] d_i;
    } s1_t;

    logic  s1_valid_reg;
    s1_t   s1_reg;
    s1_t   s1_next;
    logic  s1_ready;
    logic  s2_valid_reg;
    lane_t s2_reg;
    lane_t s2_next;
    logic  s2_ready;

    logic signed [DW-1:0] y0;
    logic signed [DW-1:0] y1;

    // handshake along the two stages
    assign s2_ready  = !s2_valid_reg || dn_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;
    assign dn_valid  = s2_valid_reg;
    assign dn_lane   = s2_reg;

    // stage 1: products, squares of A share the multipliers for magnitude
    always_comb
    begin
        y0 = (req.req_type == OP_MAG) ? req.a_re : req.b_re;
        y1 = (req.req_type == OP_MAG) ? req.a_im : req.b_im;
        s1_next.op   = req.req_type;
        s1_next.a_re = req.a_re;
        s1_next.a_im = req.a_im;
        s1_next.b_re = req.b_re;
        s1_next.b_im = req.b_im;
        s1_next.p_rr = req.a_re * y0;
        s1_next.p_ii = req.a_im * y1;
        s1_next.p_ri = req.a_re * req.b_im;
        s1_next.p_ir = req.a_im * req.b_re;
        s1_next.d_r  = req.b_re * req.b_re;
        s1_next.d_i  = req.b_im * req.b_im;
    end

    // stage 2: sums, direct results and set-up of the cell chain
    logic signed [SW-1:0] e_rr, e_ii, e_ri, e_ir;
    logic signed [SW-1:0] ea_r, ea_i, eb_r, eb_i;
    logic signed [SW-1:0] s_re, s_im;
    logic signed [SW-1:0] dv_re, dv_im;
    logic [NW-1:0]        m_re, m_im;
    logic [NW-1:0]        dm_re, dm_im;
    logic [NW-1:0]        t_re, t_im, u_re, u_im;
    logic [PW-1:0]        den;
    nar_t                 n_re, n_im;

    always_comb
    begin
        e_rr = $signed({{2{s1_reg.p_rr[PW-1]}}, s1_reg.p_rr});
        e_ii = $signed({{2{s1_reg.p_ii[PW-1]}}, s1_reg.p_ii});
        e_ri = $signed({{2{s1_reg.p_ri[PW-1]}}, s1_reg.p_ri});
        e_ir = $signed({{2{s1_reg.p_ir[PW-1]}}, s1_reg.p_ir});
        ea_r = $signed({{(SW-DW){s1_reg.a_re[DW-1]}}, s1_reg.a_re});
        ea_i = $signed({{(SW-DW){s1_reg.a_im[DW-1]}}, s1_reg.a_im});
        eb_r = $signed({{(SW-DW){s1_reg.b_re[DW-1]}}, s1_reg.b_re});
        eb_i = $signed({{(SW-DW){s1_reg.b_im[DW-1]}}, s1_reg.b_im});
        den  = s1_reg.d_r[PW-1:0] + s1_reg.d_i[PW-1:0];

        // direct results
        s_re = '0;
        s_im = '0;
        case (s1_reg.op)
            OP_ADD:
            begin
                s_re = ea_r + eb_r;
                s_im = ea_i + eb_i;
            end
            OP_SUB:
            begin
                s_re = ea_r - eb_r;
                s_im = ea_i - eb_i;
            end
            OP_MUL:
            begin
                s_re = e_rr - e_ii;
                s_im = e_ri + e_ir;
            end
            OP_NEG:
            begin
                s_re = -ea_r;
                s_im = -ea_i;
            end
            default:
            begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        m_re = mag_of(s_re);
        m_im = mag_of(s_im);
        if (s1_reg.op == OP_MUL)
        begin
            m_re = m_re >> FRAC_BITS;
            m_im = m_im >> FRAC_BITS;
        end
        n_re = sat_val(s_re[SW-1], m_re);
        n_im = sat_val(s_im[SW-1], m_im);

        // division numerators
        dv_re = e_rr + e_ii;
        dv_im = e_ir - e_ri;
        dm_re = mag_of(dv_re);
        dm_im = mag_of(dv_im);
        t_re  = dm_re >> (DW - FRAC_BITS);
        t_im  = dm_im >> (DW - FRAC_BITS);
        u_re  = dm_re << FRAC_BITS;
        u_im  = dm_im << FRAC_BITS;

        s2_next.late    = LATE_NONE;
        s2_next.pre_re  = n_re.val;
        s2_next.pre_im  = n_im.val;
        s2_next.pre_st  = (n_re.sat || n_im.sat) ? ST_SAT : ST_OK;
        s2_next.neg_re  = dv_re[SW-1];
        s2_next.neg_im  = dv_im[SW-1];
        s2_next.ovf_re  = t_re >= {1'b0, den};
        s2_next.ovf_im  = t_im >= {1'b0, den};
        s2_next.den     = den;
        s2_next.drem_re = t_re[PW-1:0];
        s2_next.drem_im = t_im[PW-1:0];
        s2_next.dsh_re  = u_re[DW-1:0];
        s2_next.dsh_im  = u_im[DW-1:0];
        s2_next.q_re    = '0;
        s2_next.q_im    = '0;
        s2_next.srem    = '0;
        s2_next.root    = '0;
        s2_next.vsh     = s1_reg.p_rr[PW-1:0] + s1_reg.p_ii[PW-1:0];

        case (s1_reg.op)
            OP_DIV:
            begin
                if (den == '0)
                begin
                    s2_next.pre_re = '0;
                    s2_next.pre_im = '0;
                    s2_next.pre_st = ST_DZ;
                end
                else
                begin
                    s2_next.late = LATE_DIV;
                end
            end
            OP_MAG:
            begin
                s2_next.late = LATE_MAG;
            end
            default:
            begin
                s2_next.late = LATE_NONE;
            end
        endcase
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

FILE: hw/rtl/cau_cell.sv
`timescale 1ns / 1ps

module cau_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  cau_pkg::lane_t up_lane,
    output logic           dn_valid,
    input  logic           dn_ready,
    output cau_pkg::lane_t dn_lane
);
    import cau_pkg::*;

    logic          valid_reg;
    lane_t         lane_reg;
    lane_t         lane_next;
    logic [PW:0]   tr_re;
    logic [PW:0]   tr_im;
    logic [DW+3:0] st;
    logic [DW+3:0] trial;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_lane  = lane_reg;

    // one restoring division step per lane and one square-root step
    always_comb
    begin
        lane_next = up_lane;

        tr_re = {up_lane.drem_re, up_lane.dsh_re[DW-1]};
        tr_im = {up_lane.drem_im, up_lane.dsh_im[DW-1]};
        lane_next.dsh_re = {up_lane.dsh_re[DW-2:0], 1'b0};
        lane_next.dsh_im = {up_lane.dsh_im[DW-2:0], 1'b0};
        if (tr_re >= {1'b0, up_lane.den})
        begin
            tr_re = tr_re - {1'b0, up_lane.den};
            lane_next.q_re = {up_lane.q_re[DW-2:0], 1'b1};
        end
        else
        begin
            lane_next.q_re = {up_lane.q_re[DW-2:0], 1'b0};
        end
        if (tr_im >= {1'b0, up_lane.den})
        begin
            tr_im = tr_im - {1'b0, up_lane.den};
            lane_next.q_im = {up_lane.q_im[DW-2:0], 1'b1};
        end
        else
        begin
            lane_next.q_im = {up_lane.q_im[DW-2:0], 1'b0};
        end
        lane_next.drem_re = tr_re[PW-1:0];
        lane_next.drem_im = tr_im[PW-1:0];

        st    = {up_lane.srem[DW+1:0], up_lane.vsh[PW-1:PW-2]};
        trial = {2'b00, up_lane.root, 2'b01};
        lane_next.vsh = {up_lane.vsh[PW-3:0], 2'b00};
        if (st >= trial)
        begin
            lane_next.srem = st - trial;
            lane_next.root = {up_lane.root[DW-2:0], 1'b1};
        end
        else
        begin
            lane_next.srem = st;
            lane_next.root = {up_lane.root[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            lane_reg <= lane_next;
        end
    end

endmodule

FILE: hw/rtl/cau_back.sv
`timescale 1ns / 1ps

module cau_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  cau_pkg::lane_t up_lane,
    cau_res_if.source      res
);
    import cau_pkg::*;

    logic          valid_reg;
    logic [DW-1:0] re_reg, re_next;
    logic [DW-1:0] im_reg, im_next;
    st_t           st_reg, st_next;
    nar_t          n_re, n_im;
    logic [NW-1:0] qm_re, qm_im;

    assign up_ready   = !valid_reg || res.ready;
    assign res.valid  = valid_reg;
    assign res.res_re = re_reg;
    assign res.res_im = im_reg;
    assign res.status = st_reg;

    // finish quotient and root results, or pass direct results through
    always_comb
    begin
        qm_re = up_lane.ovf_re ? '1 : NW'(up_lane.q_re);
        qm_im = up_lane.ovf_im ? '1 : NW'(up_lane.q_im);
        n_re  = sat_val(up_lane.neg_re, qm_re);
        n_im  = sat_val(up_lane.neg_im, qm_im);
        case (up_lane.late)
            LATE_DIV:
            begin
                re_next = n_re.val;
                im_next = n_im.val;
                st_next = (n_re.sat || n_im.sat) ? ST_SAT : ST_OK;
            end
            LATE_MAG:
            begin
                n_re    = sat_val(1'b0, NW'(up_lane.root));
                re_next = n_re.val;
                im_next = '0;
                st_next = n_re.sat ? ST_SAT : ST_OK;
            end
            default:
            begin
                re_next = up_lane.pre_re;
                im_next = up_lane.pre_im;
                st_next = up_lane.pre_st;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

endmodule

FILE: hw/rtl/complex_arith_unit.sv
`timescale 1ns / 1ps
// complex_arith_unit: complex add, subtract, multiply, divide, negate and
// magnitude on signed Q8.8 parts.
// req: sink channel, one word per operation: req_type, a_re, a_im, b_re, b_im.
// res: source channel, one word per request: res_re, res_im, status
// (ok, saturated or divide by zero), always in request order.
// pipeline: 19 registers: two front stages (products, then sums), a row of
// 16 cells that each make one quotient bit of both quotient parts and one
// bit of the square root, and the output register.
// throughput: one word per cycle while res.ready is high; a stage takes a
// new word each cycle unless it is full and the stage after it stalls.
// each stage has its own valid bit, so a stalled res only holds the words
// behind it until the bubbles in the row are filled; req.ready drops once
// every stage is full.
// reset clears all valid bits; no word is held across reset.
module complex_arith_unit (
    input  logic      clk,
    input  logic      rst_n,
    cau_req_if.sink   req,
    cau_res_if.source res
);
    import cau_pkg::*;

    logic  c_valid [NCELLS+1];
    logic  c_ready [NCELLS+1];
    lane_t c_lane  [NCELLS+1];

    // products and sums
    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dn_valid (c_valid[0]),
        .dn_ready (c_ready[0]),
        .dn_lane  (c_lane[0])
    );

    // row of division and square-root cells
    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        cau_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_valid[g]),
            .up_ready (c_ready[g]),
            .up_lane  (c_lane[g]),
            .dn_valid (c_valid[g+1]),
            .dn_ready (c_ready[g+1]),
            .dn_lane  (c_lane[g+1])
        );
    end

    // result selection and output register
    cau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (c_valid[NCELLS]),
        .up_ready (c_ready[NCELLS]),
        .up_lane  (c_lane[NCELLS]),
        .res      (res)
    );

endmodule
